/* rtl/crs_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the closest ray-sphere hit block.
package crs_pkg;

    localparam int unsigned MAX_SPHERES = 8;
    localparam int unsigned IDX_W       = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int unsigned CMP_W       = 8;
    localparam int unsigned IN_DATA_W   = 328;
    localparam int unsigned OUT_DATA_W  = 232;

    localparam logic KIND_LOAD        = 1'b0;
    localparam logic KIND_TRACE       = 1'b1;
    localparam logic REG_SPHERE_COUNT = 1'b0;

    localparam logic signed [31:0] MISS_DIST = 32'shFFFF0000;
    localparam logic signed [31:0] S32_MAX   = 32'sh7FFFFFFF;

    localparam logic [3:0] STEP_SPH_LAST = 4'd13;
    localparam logic [3:0] STEP_LOC_LAST = 4'd7;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        r;
    } t_sphere;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEL,
        S_MUL,
        S_CHK,
        S_SQRT,
        S_DIVT,
        S_ROT,
        S_LOC,
        S_LEN,
        S_NRM,
        S_DONE
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = S32_MAX;
        end else if (v < -64'sd2147483648) begin
            res = -32'sd2147483648;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] res;
        res = v[31] ? 32'(-v) : 32'(v);
        return res;
    endfunction

endpackage

/* rtl/crs_cell.sv */
`timescale 1ns / 1ps
// One sphere table cell: holds a sphere and passes it to its neighbor on a shift.
module crs_cell (
    input  logic             i_clk,
    input  logic             i_load,
    input  crs_pkg::t_sphere i_load_data,
    input  logic             i_shift,
    input  crs_pkg::t_sphere i_next,
    output crs_pkg::t_sphere o_sphere
);
    import crs_pkg::*;

    t_sphere r_sphere;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sphere <= i_load_data;
        end else if (i_shift) begin
            r_sphere <= i_next;
        end
    end

    assign o_sphere = r_sphere;

endmodule

/* rtl/crs_sqrt.sv */
`timescale 1ns / 1ps
// Iterative integer square root, two radicand bits per cycle.
module crs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_din,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_x;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [35:0] w_rem2;
    logic [35:0] w_trial;
    logic        w_ge;

    assign w_rem2  = {r_rem, r_x[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 5'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_din;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= 5'd31;
        end else if (r_busy) begin
            r_x    <= {r_x[61:0], 2'b00};
            r_rem  <= w_ge ? 34'(w_rem2 - w_trial) : 34'(w_rem2);
            r_root <= {r_root[30:0], w_ge};
            r_cnt  <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* rtl/crs_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, 48-bit dividend by 32-bit divisor, one bit per cycle.
module crs_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quo
);
    logic [47:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] w_rem2;
    logic        w_ge;

    assign w_rem2 = {r_rem, r_q[47]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == 6'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= 6'd47;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_rem2 - {1'b0, r_den}) : w_rem2[31:0];
            r_q   <= {r_q[46:0], w_ge};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

/* rtl/closest_ray_sphere_hit.sv */
`timescale 1ns / 1ps
// Closest ray-sphere hit: sphere table ring, shared multiplier, root and divide units.
//
// Input words arrive on the s_axis channel. tuser 0 is a load word: it writes one
// sphere into the table slot given in tdata and gives no result. tuser 1 is a trace
// word: the ray is tested against slots 0 .. min(sphere_count, 8)-1 and exactly one result
// word leaves on the m_axis channel (tuser is the hit flag).
// The sphere table is a ring of cells that rotates one place per sphere, so the
// sphere under test always sits in the head cell; each trace turns the ring fully.
// A tested sphere uses the multiplier and, unless rejected early, the square root
// unit and the divider; an untested slot is only selected and rotated. A hit adds
// position and normal (one root and, for a nonzero length, three divisions). Load
// words go straight into the table. The divider and root unit set the trace latency.
// The block takes one word at a time; a finished result sits in an output register,
// so the next word is accepted while m_axis is stalled, and a second result waits
// until the first has been taken.
// sphere_count lives at APB address 0. Reset clears sphere_count and all control
// state; table contents are undefined until loaded.
module closest_ray_sphere_hit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // slot, centre_x, centre_y, centre_z, radius, origin_x, origin_y, origin_z,
    // dir_x, dir_y, dir_z
    input  logic [crs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // kind
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // object_index, distance, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z
    output logic [crs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // hit
    output logic                          m_axis_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import crs_pkg::*;

    t_state r_state, n_state;

    logic [3:0]              r_cnt;
    logic [IDX_W-1:0]        r_idx;
    logic [3:0]              r_step;
    logic [1:0]              r_comp;
    logic                    r_found;
    logic [IDX_W-1:0]        r_bidx;

    logic signed [31:0]      r_org [0:2];
    logic signed [31:0]      r_dir [0:2];
    logic signed [31:0]      r_oc  [0:2];
    logic signed [31:0]      r_boc [0:2];
    logic signed [31:0]      r_bc  [0:2];
    logic signed [31:0]      r_loc [0:2];
    logic signed [31:0]      r_pos [0:2];
    logic signed [31:0]      r_nrm [0:2];
    logic signed [31:0]      r_a, r_b, r_c, r_disc, r_t;
    logic signed [49:0]      r_acc;
    logic signed [47:0]      r_pbb;
    logic [63:0]             r_len2;
    logic [31:0]             r_len;
    logic signed [63:0]      r_prod;

    logic                    r_out_valid;
    logic                    r_out_user;
    logic [OUT_DATA_W-1:0]   r_out_data;

    logic signed [31:0]      w_ma, w_mb;
    logic signed [47:0]      w_p;
    logic signed [31:0]      w_rad;
    logic                    w_in_acc;
    logic                    w_active;
    logic                    w_last;
    logic [CMP_W-1:0]        w_n;
    logic                    w_ring_shift;
    logic                    w_out_load;

    logic                    w_sq_start, w_sq_done;
    logic [63:0]             w_sq_din;
    logic [31:0]             w_sq_root;
    logic                    w_dv_start, w_dv_done;
    logic [47:0]             w_dv_num, w_dv_quo;
    logic [31:0]             w_dv_den;

    logic signed [63:0]      w_near;
    logic [31:0]             w_den;
    logic signed [31:0]      w_t;
    logic                    w_better;
    logic signed [31:0]      w_loc_new;
    logic signed [31:0]      w_nrm_new;
    logic [1:0]              w_comp_nxt;

    t_sphere                 w_cell [0:MAX_SPHERES-1];
    t_sphere                 w_head;
    t_sphere                 w_load_data;

    // ---------------- sphere table ring ----------------
    assign w_load_data.cx = s_axis_tdata[34:3];
    assign w_load_data.cy = s_axis_tdata[66:35];
    assign w_load_data.cz = s_axis_tdata[98:67];
    assign w_load_data.r  = s_axis_tdata[129:99];

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < MAX_SPHERES; g++) begin : g_cell
        localparam int unsigned NXT = (g + 1) % MAX_SPHERES;
        crs_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_in_acc && (s_axis_tuser == KIND_LOAD) &&
                          (CMP_W'(s_axis_tdata[2:0]) == CMP_W'(g))),
            .i_load_data (w_load_data),
            .i_shift     (w_ring_shift),
            .i_next      (w_cell[NXT]),
            .o_sphere    (w_cell[g])
        );
    end

    assign w_head = w_cell[0];
    assign w_rad  = signed'({1'b0, w_head.r});

    // ---------------- shared units ----------------
    crs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_din   (w_sq_din),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    crs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_dv_num),
        .i_den   (w_dv_den),
        .o_done  (w_dv_done),
        .o_quo   (w_dv_quo)
    );

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SPHERE_COUNT) ? {28'd0, r_cnt} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_SPHERE_COUNT)) begin
            r_cnt <= pwdata[3:0];
        end
    end

    assign w_n      = (CMP_W'(r_cnt) > CMP_W'(MAX_SPHERES)) ? CMP_W'(MAX_SPHERES)
                                                          : CMP_W'(r_cnt);
    assign w_active = CMP_W'(r_idx) < w_n;
    assign w_last   = (r_idx == IDX_W'(MAX_SPHERES - 1));

    // ---------------- multiplier ----------------
    // The product is registered; each step issues one product and consumes the last.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_MUL) begin
            unique case (r_step)
                4'd1:    begin w_ma = r_dir[0]; w_mb = r_dir[0]; end
                4'd2:    begin w_ma = r_dir[1]; w_mb = r_dir[1]; end
                4'd3:    begin w_ma = r_dir[2]; w_mb = r_dir[2]; end
                4'd4:    begin w_ma = r_dir[0]; w_mb = r_oc[0];  end
                4'd5:    begin w_ma = r_dir[1]; w_mb = r_oc[1];  end
                4'd6:    begin w_ma = r_dir[2]; w_mb = r_oc[2];  end
                4'd7:    begin w_ma = r_oc[0];  w_mb = r_oc[0];  end
                4'd8:    begin w_ma = r_oc[1];  w_mb = r_oc[1];  end
                4'd9:    begin w_ma = r_oc[2];  w_mb = r_oc[2];  end
                4'd10:   begin w_ma = w_rad;    w_mb = w_rad;    end
                4'd11:   begin w_ma = r_b;      w_mb = r_b;      end
                4'd12:   begin w_ma = r_a;      w_mb = r_c;      end
                default: begin w_ma = '0;       w_mb = '0;       end
            endcase
        end else if (r_state == S_LOC) begin
            unique case (r_step)
                4'd1:    begin w_ma = r_dir[0]; w_mb = r_t;      end
                4'd2:    begin w_ma = r_dir[1]; w_mb = r_t;      end
                4'd3:    begin w_ma = r_dir[2]; w_mb = r_t;      end
                4'd4:    begin w_ma = r_loc[0]; w_mb = r_loc[0]; end
                4'd5:    begin w_ma = r_loc[1]; w_mb = r_loc[1]; end
                4'd6:    begin w_ma = r_loc[2]; w_mb = r_loc[2]; end
                default: begin w_ma = '0;       w_mb = '0;       end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // Upper bits of the product are the floor of product / 2^16.
    assign w_p = r_prod[63:16];

    // ---------------- helpers for the datapath ----------------
    assign w_near = -64'(r_b) - $signed({32'd0, w_sq_root});
    assign w_den  = r_a[30] ? 32'h7FFF_FFFF : {r_a[30:0], 1'b0};
    assign w_t    = (|w_dv_quo[47:31]) ? S32_MAX : signed'(w_dv_quo[31:0]);
    assign w_better = (w_t > 32'sd0) && (!r_found || (w_t < r_t));
    assign w_comp_nxt = r_comp + 2'd1;

    always_comb begin
        w_loc_new = '0;
        unique case (r_step)
            4'd2:    w_loc_new = sat32(64'(r_boc[0]) + 64'(w_p));
            4'd3:    w_loc_new = sat32(64'(r_boc[1]) + 64'(w_p));
            4'd4:    w_loc_new = sat32(64'(r_boc[2]) + 64'(w_p));
            default: w_loc_new = '0;
        endcase
    end

    assign w_nrm_new = r_loc[r_comp][31] ? sat32(-$signed({16'd0, w_dv_quo}))
                                         : sat32($signed({16'd0, w_dv_quo}));

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_sq_start   = 1'b0;
        w_sq_din     = '0;
        w_dv_start   = 1'b0;
        w_dv_num     = '0;
        w_dv_den     = '0;
        w_ring_shift = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && (s_axis_tuser == KIND_TRACE)) begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                n_state = w_active ? S_MUL : S_ROT;
            end
            S_MUL: begin
                if (r_step == STEP_SPH_LAST) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // A negative discriminant or a zero direction is no hit.
                if (r_disc[31] || (r_a == 32'sd0)) begin
                    n_state = S_ROT;
                end else begin
                    w_sq_start = 1'b1;
                    w_sq_din   = {16'd0, r_disc, 16'd0};
                    n_state    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sq_done) begin
                    if (w_near > 64'sd0) begin
                        w_dv_start = 1'b1;
                        w_dv_num   = {w_near[31:0], 16'd0};
                        w_dv_den   = w_den;
                        n_state    = S_DIVT;
                    end else begin
                        n_state = S_ROT;
                    end
                end
            end
            S_DIVT: begin
                if (w_dv_done) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                w_ring_shift = 1'b1;
                if (w_last) begin
                    n_state = r_found ? S_LOC : S_DONE;
                end else begin
                    n_state = S_SEL;
                end
            end
            S_LOC: begin
                if (r_step == STEP_LOC_LAST) begin
                    w_sq_start = 1'b1;
                    w_sq_din   = r_len2 + $unsigned(r_prod);
                    n_state    = S_LEN;
                end
            end
            S_LEN: begin
                if (w_sq_done) begin
                    if (w_sq_root == 32'd0) begin
                        n_state = S_DONE;
                    end else begin
                        w_dv_start = 1'b1;
                        w_dv_num   = {abs32(r_loc[0]), 16'd0};
                        w_dv_den   = w_sq_root;
                        n_state    = S_NRM;
                    end
                end
            end
            S_NRM: begin
                if (w_dv_done) begin
                    if (r_comp == 2'd2) begin
                        n_state = S_DONE;
                    end else begin
                        w_dv_start = 1'b1;
                        w_dv_num   = {abs32(r_loc[w_comp_nxt]), 16'd0};
                        w_dv_den   = r_len;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_idx   <= '0;
            r_step  <= '0;
            r_comp  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (s_axis_tuser == KIND_TRACE)) begin
                        r_org[0] <= s_axis_tdata[161:130];
                        r_org[1] <= s_axis_tdata[193:162];
                        r_org[2] <= s_axis_tdata[225:194];
                        r_dir[0] <= s_axis_tdata[257:226];
                        r_dir[1] <= s_axis_tdata[289:258];
                        r_dir[2] <= s_axis_tdata[321:290];
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_bidx   <= '0;
                    end
                end
                S_SEL: begin
                    r_oc[0] <= sat32(64'(r_org[0]) - 64'(w_head.cx));
                    r_oc[1] <= sat32(64'(r_org[1]) - 64'(w_head.cy));
                    r_oc[2] <= sat32(64'(r_org[2]) - 64'(w_head.cz));
                    r_step  <= 4'd1;
                end
                S_MUL: begin
                    r_step <= r_step + 4'd1;
                    unique case (r_step)
                        4'd2:    r_acc  <= 50'(w_p);
                        4'd3:    r_acc  <= r_acc + 50'(w_p);
                        4'd4:    r_a    <= sat32(64'(r_acc) + 64'(w_p));
                        4'd5:    r_acc  <= 50'(w_p);
                        4'd6:    r_acc  <= r_acc + 50'(w_p);
                        4'd7:    r_b    <= sat32(64'(sat32(64'(r_acc) + 64'(w_p))) <<< 1);
                        4'd8:    r_acc  <= 50'(w_p);
                        4'd9:    r_acc  <= r_acc + 50'(w_p);
                        4'd10:   r_acc  <= 50'(sat32(64'(r_acc) + 64'(w_p)));
                        4'd11:   r_c    <= sat32(64'(r_acc) - 64'(w_p));
                        4'd12:   r_pbb  <= w_p;
                        4'd13:   r_disc <= sat32(64'(r_pbb) - (64'(w_p) <<< 2));
                        default: r_acc  <= r_acc;
                    endcase
                end
                S_DIVT: begin
                    if (w_dv_done && w_better) begin
                        r_found  <= 1'b1;
                        r_t      <= w_t;
                        r_bidx   <= r_idx;
                        r_boc[0] <= r_oc[0];
                        r_boc[1] <= r_oc[1];
                        r_boc[2] <= r_oc[2];
                        r_bc[0]  <= w_head.cx;
                        r_bc[1]  <= w_head.cy;
                        r_bc[2]  <= w_head.cz;
                    end
                end
                S_ROT: begin
                    r_idx  <= r_idx + IDX_W'(1);
                    r_step <= 4'd1;
                    r_comp <= '0;
                end
                S_LOC: begin
                    r_step <= r_step + 4'd1;
                    unique case (r_step)
                        4'd2: begin
                            r_loc[0] <= w_loc_new;
                            r_pos[0] <= sat32(64'(w_loc_new) + 64'(r_bc[0]));
                        end
                        4'd3: begin
                            r_loc[1] <= w_loc_new;
                            r_pos[1] <= sat32(64'(w_loc_new) + 64'(r_bc[1]));
                        end
                        4'd4: begin
                            r_loc[2] <= w_loc_new;
                            r_pos[2] <= sat32(64'(w_loc_new) + 64'(r_bc[2]));
                        end
                        4'd5:    r_len2 <= $unsigned(r_prod);
                        4'd6:    r_len2 <= r_len2 + $unsigned(r_prod);
                        default: r_len2 <= r_len2;
                    endcase
                end
                S_LEN: begin
                    if (w_sq_done) begin
                        r_len <= w_sq_root;
                        if (w_sq_root == 32'd0) begin
                            r_nrm[0] <= '0;
                            r_nrm[1] <= '0;
                            r_nrm[2] <= '0;
                        end
                    end
                end
                S_NRM: begin
                    if (w_dv_done) begin
                        r_nrm[r_comp] <= w_nrm_new;
                        r_comp        <= w_comp_nxt;
                    end
                end
                default: r_step <= r_step;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_user <= r_found;
            if (r_found) begin
                r_out_data <= {5'd0, r_nrm[2], r_nrm[1], r_nrm[0],
                               r_pos[2], r_pos[1], r_pos[0], r_t, 3'(r_bidx)};
            end else begin
                r_out_data <= {5'd0, 192'd0, MISS_DIST, 3'd0};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
